FILE: src/mbs_pkg.sv
// Shared types, codes, constants and the CRC-16/MODBUS byte update for the frame sniffer.
`timescale 1ns / 1ps

package mbs_pkg;

   // Frame sizing
   localparam int MAX_FRAME = 16;
   localparam int COUNT_W   = $clog2(MAX_FRAME + 2);
   localparam int IDX_W     = $clog2(MAX_FRAME);
   localparam logic [COUNT_W-1:0] REQ_BYTES   = COUNT_W'(8);
   localparam logic [COUNT_W-1:0] ANS_BYTES   = COUNT_W'(7);
   localparam logic [COUNT_W-1:0] COMBO_BYTES = COUNT_W'(15);
   localparam logic [COUNT_W-1:0] FULL_COUNT  = COUNT_W'(MAX_FRAME);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Configuration register indexes
   localparam logic CSR_LINK_ENABLED = 1'b0;
   localparam logic CSR_MANUAL_MASK  = 1'b1;

   // Register addresses of the station
   localparam logic [15:0] REG_WIND_SPEED = 16'd30001;
   localparam logic [15:0] REG_WIND_DIR   = 16'd30201;
   localparam logic [15:0] REG_AIR_TEMP   = 16'd30401;
   localparam logic [15:0] REG_HUMIDITY   = 16'd30601;
   localparam logic [15:0] REG_DEWPOINT   = 16'd30701;
   localparam logic [15:0] REG_PRESSURE   = 16'd30801;

   // Acceptance limits on the raw tenths value (pressure limits solved for v*760)
   localparam logic signed [15:0] WIND_LIMIT  = 16'sd2000;
   localparam logic signed [15:0] TEMP_LIMIT  = 16'sd400;
   localparam logic signed [15:0] HUMID_LIMIT = 16'sd1000;
   localparam logic signed [15:0] PRESS_MIN   = 16'sd6665;
   localparam logic signed [15:0] PRESS_MAX   = 16'sd9330;

   // floor(a*760/1013) == (a*PRESS_MULT) >> PRESS_SHIFT for all a <= 32768
   localparam int PRESS_SHIFT = 25;
   localparam logic [24:0] PRESS_MULT = 25'd25174105;

   // Manual entry mask bits
   localparam int MAN_WIND  = 0;
   localparam int MAN_TEMP  = 1;
   localparam int MAN_HUMID = 2;
   localparam int MAN_PRESS = 3;

   typedef enum logic {
      KIND_BYTE    = 1'b0,
      KIND_SILENCE = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_VALUE    = 3'd0,
      ST_LATCHED  = 3'd1,
      ST_CRC_ERR  = 3'd2,
      ST_UNKNOWN  = 3'd3,
      ST_BAD_LEN  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PAR_WIND_SPEED = 3'd0,
      PAR_WIND_DIR   = 3'd1,
      PAR_AIR_TEMP   = 3'd2,
      PAR_HUMIDITY   = 3'd3,
      PAR_DEWPOINT   = 3'd4,
      PAR_PRESSURE   = 3'd5
   } param_type;

   // Frame collector state seen by the decoder
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [15:0]        running_crc;
      logic [15:0]        req_crc;
      logic [15:0]        ans_crc;
      logic [15:0]        req_register;
      logic [15:0]        ans_word;
      logic [15:0]        combo_word;
   } frame_type;

   typedef struct packed {
      status_type         status;
      param_type          param;
      logic signed [15:0] raw_value;
      logic signed [15:0] scaled_value;
      logic               accepted;
   } result_type;

   typedef struct packed {
      logic        update;
      logic [15:0] value;
   } latch_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: src/mbs_req_if.sv
// Input channel: received bytes and line-silence events.
`timescale 1ns / 1ps

interface mbs_req_if import mbs_pkg::*; ();
   logic        valid;
   logic        ready;
   kind_type    kind;
   logic [7:0]  data_byte;

   modport source (output valid, kind, data_byte, input ready);
   modport sink   (input valid, kind, data_byte, output ready);
endinterface

FILE: src/mbs_rsp_if.sv
// Result channel: decoded frame reports.
`timescale 1ns / 1ps

interface mbs_rsp_if import mbs_pkg::*; ();
   logic               valid;
   logic               ready;
   status_type         status;
   param_type          param;
   logic signed [15:0] raw_value;
   logic signed [15:0] scaled_value;
   logic               accepted;

   modport source (output valid, status, param, raw_value, scaled_value, accepted,
                   input ready);
   modport sink   (input valid, status, param, raw_value, scaled_value, accepted,
                   output ready);
endinterface

FILE: src/mbs_frame.sv
// Frame collector: byte count, running and snapshot CRCs, stored frame bytes.
`timescale 1ns / 1ps

module mbs_frame import mbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_in,
   input  logic       clear,
   input  logic [7:0] data_byte,
   output frame_type  frame
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        crc_ff, crc_in;
   logic [15:0]        req_crc_ff, req_crc_in;
   logic [15:0]        ans_crc_ff, ans_crc_in;
   logic [7:0]         store_ff [MAX_FRAME];
   logic [15:0]        crc_next;
   logic               take;

   assign take     = byte_in && (count_ff <= FULL_COUNT);
   assign crc_next = crc_byte(crc_ff, data_byte);

   always_comb begin
      count_in   = count_ff;
      crc_in     = crc_ff;
      req_crc_in = req_crc_ff;
      ans_crc_in = ans_crc_ff;
      if (clear) begin
         count_in   = '0;
         crc_in     = CRC_INIT;
         req_crc_in = CRC_INIT;
         ans_crc_in = CRC_INIT;
      end else if (take) begin
         crc_in   = crc_next;
         count_in = count_ff + COUNT_W'(1);
         if (count_ff >= REQ_BYTES) begin
            ans_crc_in = crc_byte(ans_crc_ff, data_byte);
         end
         // snapshot the request CRC as its eighth byte arrives
         if (count_ff + COUNT_W'(1) == REQ_BYTES) begin
            req_crc_in = crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         crc_ff     <= CRC_INIT;
         req_crc_ff <= CRC_INIT;
         ans_crc_ff <= CRC_INIT;
      end else begin
         count_ff   <= count_in;
         crc_ff     <= crc_in;
         req_crc_ff <= req_crc_in;
         ans_crc_ff <= ans_crc_in;
      end
   end

   // drop bytes past the end of the store
   always_ff @(posedge clock) begin
      if (!clear && take && (count_ff < FULL_COUNT)) begin
         store_ff[count_ff[IDX_W-1:0]] <= data_byte;
      end
   end

   assign frame.count        = count_ff;
   assign frame.running_crc  = crc_ff;
   assign frame.req_crc      = req_crc_ff;
   assign frame.ans_crc      = ans_crc_ff;
   assign frame.req_register = {store_ff[2], store_ff[3]};
   assign frame.ans_word     = {store_ff[3], store_ff[4]};
   assign frame.combo_word   = {store_ff[11], store_ff[12]};

endmodule

FILE: src/mbs_decode.sv
// Frame decoder: length and CRC checks, register classification, scaling, range check.
`timescale 1ns / 1ps

module mbs_decode import mbs_pkg::*; (
   input  frame_type   frame,
   input  logic [15:0] pending_register,
   input  logic        link_enabled,
   input  logic [3:0]  manual_mask,
   output result_type  result,
   output latch_type   latch
);

   logic [15:0]        reg_addr;
   logic signed [15:0] v;
   logic               value_frame;
   logic [16:0]        mag;
   logic [41:0]        press_prod;
   logic [15:0]        press_q;
   logic signed [15:0] press_scaled;
   result_type         value_res;
   logic               in_range;
   logic               mask_bit;
   logic               storable;

   // 7-byte answers use the latched register; a combined frame carries its own
   assign reg_addr = (frame.count == COMBO_BYTES) ? frame.req_register : pending_register;
   assign v        = (frame.count == COMBO_BYTES) ? $signed(frame.combo_word)
                                                  : $signed(frame.ans_word);

   // pressure: trunc(v*760/1013) by reciprocal multiply on the magnitude
   assign mag          = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
   assign press_prod   = {25'd0, mag} * {17'd0, PRESS_MULT};
   assign press_q      = press_prod[PRESS_SHIFT +: 16];
   assign press_scaled = v[15] ? $signed(16'd0 - press_q) : $signed(press_q);

   always_comb begin
      value_res.status       = ST_VALUE;
      value_res.param        = PAR_WIND_SPEED;
      value_res.raw_value    = v;
      value_res.scaled_value = v;
      value_res.accepted     = 1'b0;
      in_range = 1'b0;
      mask_bit = 1'b0;
      storable = 1'b1;
      unique case (reg_addr)
         REG_WIND_SPEED: begin
            in_range = (v >= 16'sd0) && (v < WIND_LIMIT);
            mask_bit = manual_mask[MAN_WIND];
         end
         REG_WIND_DIR: begin
            value_res.param = PAR_WIND_DIR;
            storable = 1'b0;
         end
         REG_AIR_TEMP: begin
            value_res.param = PAR_AIR_TEMP;
            in_range = (v > -TEMP_LIMIT) && (v < TEMP_LIMIT);
            mask_bit = manual_mask[MAN_TEMP];
         end
         REG_HUMIDITY: begin
            value_res.param = PAR_HUMIDITY;
            in_range = (v >= 16'sd0) && (v <= HUMID_LIMIT);
            mask_bit = manual_mask[MAN_HUMID];
         end
         REG_DEWPOINT: begin
            value_res.param = PAR_DEWPOINT;
            storable = 1'b0;
         end
         REG_PRESSURE: begin
            value_res.param        = PAR_PRESSURE;
            value_res.scaled_value = press_scaled;
            in_range = (v >= PRESS_MIN) && (v <= PRESS_MAX);
            mask_bit = manual_mask[MAN_PRESS];
         end
         default: begin
            value_res.status       = ST_UNKNOWN;
            value_res.scaled_value = '0;
            storable = 1'b0;
         end
      endcase
      value_res.accepted = storable && in_range && link_enabled && !mask_bit;
   end

   assign value_frame = 1'b1;

   always_comb begin
      result.status       = ST_BAD_LEN;
      result.param        = PAR_WIND_SPEED;
      result.raw_value    = '0;
      result.scaled_value = '0;
      result.accepted     = 1'b0;
      latch.update = 1'b1;
      latch.value  = '0;
      unique case (frame.count)
         REQ_BYTES: begin
            if (frame.req_crc != 16'h0000) begin
               result.status = ST_CRC_ERR;
            end else begin
               result.status = ST_LATCHED;
               latch.value   = frame.req_register;
            end
         end
         ANS_BYTES: begin
            if (frame.running_crc != 16'h0000) begin
               result.status = ST_CRC_ERR;
            end else if (value_frame) begin
               result = value_res;
            end
         end
         COMBO_BYTES: begin
            if ((frame.req_crc != 16'h0000) || (frame.ans_crc != 16'h0000)) begin
               result.status = ST_CRC_ERR;
            end else if (value_frame) begin
               result = value_res;
            end
         end
         default: begin
            // bad length keeps the latch
            latch.update = 1'b0;
         end
      endcase
   end

endmodule

FILE: src/modbus_meteo_frame_sniffer.sv
// Top level of the Modbus RTU weather frame sniffer.
`timescale 1ns / 1ps

// Passive listener on a Modbus RTU line. Feed it every received byte (kind byte)
// and a silence item when the line goes quiet; each silence that ends a non-empty
// frame gives one report: a latched request, a decoded weather value with its
// acceptance flag, a CRC error, an unknown register or a bad length. Items are
// taken one per clock unless the input stalls, and a report appears in the output
// register on the cycle after its silence is taken. The input stalls only while
// that register holds a report the sink has not taken. The longest path is the
// CRC byte update on the byte side and, on the report side, the 17 x 25 bit
// reciprocal multiply that converts pressure to tenths of mmHg. Write the
// configuration only while no report is outstanding.
module modbus_meteo_frame_sniffer import mbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mbs_req_if.sink     req_if,
   mbs_rsp_if.source   rsp_if,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);

   logic        link_enabled_ff, link_enabled_in;
   logic [3:0]  manual_mask_ff, manual_mask_in;
   logic [15:0] pending_ff, pending_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;

   logic        req_fire;
   logic        byte_in;
   logic        silence;
   logic        report;
   frame_type   frame;
   result_type  dec_result;
   latch_type   dec_latch;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign byte_in      = req_fire && (req_if.kind == KIND_BYTE);
   assign silence      = req_fire && (req_if.kind == KIND_SILENCE);
   assign report       = silence && (frame.count != '0);

   mbs_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .byte_in   (byte_in),
      .clear     (silence),
      .data_byte (req_if.data_byte),
      .frame     (frame)
   );

   mbs_decode u_decode (
      .frame            (frame),
      .pending_register (pending_ff),
      .link_enabled     (link_enabled_ff),
      .manual_mask      (manual_mask_ff),
      .result           (dec_result),
      .latch            (dec_latch)
   );

   always_comb begin
      link_enabled_in = link_enabled_ff;
      manual_mask_in  = manual_mask_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LINK_ENABLED: link_enabled_in = csr_wdata[0];
            CSR_MANUAL_MASK:  manual_mask_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      pending_in = pending_ff;
      if (report && dec_latch.update) begin
         pending_in = dec_latch.value;
      end
   end

   // load on a report, drop once the sink takes it
   assign rsp_valid_in = report || (rsp_valid_ff && !rsp_if.ready);
   assign rsp_in       = report ? dec_result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_enabled_ff <= 1'b0;
         manual_mask_ff  <= '0;
         pending_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         link_enabled_ff <= link_enabled_in;
         manual_mask_ff  <= manual_mask_in;
         pending_ff      <= pending_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_ff.status;
   assign rsp_if.param        = rsp_ff.param;
   assign rsp_if.raw_value    = rsp_ff.raw_value;
   assign rsp_if.scaled_value = rsp_ff.scaled_value;
   assign rsp_if.accepted     = rsp_ff.accepted;

   a_report_loads: assert property (@(posedge clock) disable iff (reset)
      report |=> rsp_valid_ff)
      else $error("report not loaded into output register");

   a_silence_clears: assert property (@(posedge clock) disable iff (reset)
      silence |=> (frame.count == '0))
      else $error("frame not cleared after silence");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      frame.count <= FULL_COUNT + COUNT_W'(1))
      else $error("byte count past saturation");

   a_accept_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.accepted) |-> (rsp_ff.status == ST_VALUE))
      else $error("accepted flag on a non-value report");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the Modbus RTU weather frame sniffer: byte traffic in, reports checked.
`timescale 1ns / 1ps

module testbench;
   import mbs_pkg::*;

   localparam int QUIET_LIMIT  = 4000;
   localparam int PHASES       = 6;
   localparam int RANDOM_ITEMS = 90;
   localparam int PRINT_LIMIT  = 50;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_plan_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } line_item_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic       csr_index;
   logic [3:0] csr_wdata;

   mbs_req_if req_ch ();
   mbs_rsp_if rsp_ch ();

   modbus_meteo_frame_sniffer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   line_item_type line_queue[$];
   result_type    expected_reports[$];
   idle_plan_type idle_plan = IDLE_NONE;
   int         queued_count;
   int         mismatch_count;
   int         quiet_cycles;
   logic       req_taken;
   logic [15:0] wire_crc;

   // Listener mirror: frame collector, latched register, configuration
   logic [COUNT_W-1:0] frame_len;
   logic [15:0]        crc_all;
   logic [15:0]        crc_req;
   logic [15:0]        crc_ans;
   logic [7:0]         frame_buf[MAX_FRAME];
   logic [15:0]        latched_reg;
   logic               cfg_link;
   logic [3:0]         cfg_manual;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Reflected CRC-16, one data bit per step, LSB first
   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      logic        feedback;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
         feedback = acc[0] ^ b[i];
         acc = acc >> 1;
         if (feedback) acc = acc ^ CRC_POLY;
      end
      return acc;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH %0t: %s", $realtime, msg);
   endtask

   // ---------------------------------------------------------------- predictor

   task automatic clear_frame();
      frame_len = '0;
      crc_all   = CRC_INIT;
      crc_req   = CRC_INIT;
      crc_ans   = CRC_INIT;
   endtask

   task automatic take_byte(input logic [7:0] b);
      // drop bytes once the count has saturated past a full frame
      if (frame_len <= FULL_COUNT) begin
         if (frame_len < FULL_COUNT) frame_buf[frame_len[IDX_W-1:0]] = b;
         crc_all = crc16_update(crc_all, b);
         if (frame_len >= REQ_BYTES) crc_ans = crc16_update(crc_ans, b);
         frame_len = frame_len + 1'b1;
         if (frame_len == REQ_BYTES) crc_req = crc_all;
      end
   endtask

   task automatic decode_value(input logic signed [15:0] word, output result_type r);
      int   v;
      int   p;
      int   scaled;
      int   man_bit;
      logic in_range;
      logic storable;
      v        = word;
      scaled   = v;
      man_bit  = MAN_WIND;
      in_range = 1'b0;
      storable = 1'b1;
      r = '0;
      r.status    = ST_VALUE;
      r.raw_value = word;
      case (latched_reg)
         REG_WIND_SPEED: begin
            r.param  = PAR_WIND_SPEED;
            in_range = v >= 0 && v < 2000;
         end
         REG_WIND_DIR: begin
            r.param  = PAR_WIND_DIR;
            storable = 1'b0;
         end
         REG_AIR_TEMP: begin
            r.param  = PAR_AIR_TEMP;
            man_bit  = MAN_TEMP;
            in_range = v > -400 && v < 400;
         end
         REG_HUMIDITY: begin
            r.param  = PAR_HUMIDITY;
            man_bit  = MAN_HUMID;
            in_range = v >= 0 && v <= 1000;
         end
         REG_DEWPOINT: begin
            r.param  = PAR_DEWPOINT;
            storable = 1'b0;
         end
         REG_PRESSURE: begin
            // hPa tenths to mmHg tenths, truncated toward zero
            p        = v * 760;
            r.param  = PAR_PRESSURE;
            man_bit  = MAN_PRESS;
            scaled   = p / 1013;
            in_range = p > 5065000 && p < 7091000;
         end
         default: begin
            r.status = ST_UNKNOWN;
            storable = 1'b0;
            scaled   = 0;
         end
      endcase
      r.scaled_value = scaled[15:0];
      r.accepted     = storable && in_range && cfg_link && !cfg_manual[man_bit];
      latched_reg    = '0;
   endtask

   task automatic take_silence();
      result_type r;
      if (frame_len != 0) begin
         r = '0;
         if (frame_len == REQ_BYTES) begin
            if (crc_req != 16'h0000) begin
               latched_reg = '0;
               r.status    = ST_CRC_ERR;
            end else begin
               latched_reg = {frame_buf[2], frame_buf[3]};
               r.status    = ST_LATCHED;
            end
         end else if (frame_len == ANS_BYTES) begin
            if (crc_all != 16'h0000) begin
               latched_reg = '0;
               r.status    = ST_CRC_ERR;
            end else begin
               decode_value({frame_buf[3], frame_buf[4]}, r);
            end
         end else if (frame_len == COMBO_BYTES) begin
            if (crc_req != 16'h0000 || crc_ans != 16'h0000) begin
               latched_reg = '0;
               r.status    = ST_CRC_ERR;
            end else begin
               latched_reg = {frame_buf[2], frame_buf[3]};
               decode_value({frame_buf[11], frame_buf[12]}, r);
            end
         end else begin
            // bad length keeps the latch
            r.status = ST_BAD_LEN;
         end
         expected_reports.push_back(r);
         clear_frame();
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic queue_item(input kind_type k, input logic [7:0] b);
      line_item_type item;
      item.kind = k;
      item.data = b;
      line_queue.push_back(item);
      queued_count++;
   endtask

   task automatic queue_byte(input logic [7:0] b);
      queue_item(KIND_BYTE, b);
      wire_crc = crc16_update(wire_crc, b);
   endtask

   task automatic queue_silence();
      queue_item(KIND_SILENCE, 8'($urandom));
   endtask

   // append the checksum low byte first; flip one bit when asked to break it
   task automatic queue_crc(input logic bad);
      logic [15:0] c;
      c = wire_crc;
      if (bad) c = c ^ (16'h0001 << $urandom_range(0, 15));
      queue_byte(c[7:0]);
      queue_byte(c[15:8]);
   endtask

   task automatic queue_request(input logic [15:0] addr, input logic bad);
      wire_crc = CRC_INIT;
      queue_byte(8'($urandom));
      queue_byte(8'h04);
      queue_byte(addr[15:8]);
      queue_byte(addr[7:0]);
      queue_byte(8'h00);
      queue_byte(8'($urandom_range(1, 125)));
      queue_crc(bad);
   endtask

   task automatic queue_answer(input logic [15:0] word, input logic bad);
      wire_crc = CRC_INIT;
      queue_byte(8'($urandom));
      queue_byte(8'h04);
      queue_byte(8'h02);
      queue_byte(word[15:8]);
      queue_byte(word[7:0]);
      queue_crc(bad);
   endtask

   // request and answer heard as one frame
   task automatic queue_poll(input logic [15:0] addr, input logic [15:0] word);
      queue_request(addr, 1'b0);
      queue_answer(word, 1'b0);
      queue_silence();
   endtask

   task automatic queue_noise(input int len);
      repeat (len) queue_byte(8'($urandom));
      queue_silence();
   endtask

   function automatic logic [15:0] pick_register();
      case ($urandom_range(0, 7))
         0:       return REG_WIND_SPEED;
         1:       return REG_WIND_DIR;
         2:       return REG_AIR_TEMP;
         3:       return REG_HUMIDITY;
         4:       return REG_DEWPOINT;
         5:       return REG_PRESSURE;
         6:       return 16'($urandom);
         default: return REG_AIR_TEMP + 16'd1;
      endcase
   endfunction

   // lo is the first value in range, hi the first one above it
   function automatic logic [15:0] pick_value(input logic [15:0] addr);
      int lo;
      int hi;
      int v;
      case (addr)
         REG_WIND_SPEED: begin lo = 0;      hi = 2000;  end
         REG_AIR_TEMP:   begin lo = -399;   hi = 400;   end
         REG_HUMIDITY:   begin lo = 0;      hi = 1001;  end
         REG_PRESSURE:   begin lo = 6665;   hi = 9331;  end
         default:        begin lo = -32767; hi = 32767; end
      endcase
      case ($urandom_range(0, 7))
         0:       v = lo - 1;
         1:       v = lo;
         2:       v = hi - 1;
         3:       v = hi;
         4:       v = -32768;
         5:       v = 32767;
         6:       v = lo + int'($urandom_range(0, hi - lo - 1));
         default: v = int'($urandom);
      endcase
      return 16'(v);
   endfunction

   task automatic directed_frames();
      queue_silence();
      queue_request(REG_WIND_SPEED, 1'b0);
      queue_silence();
      queue_answer(16'd1999, 1'b0);
      queue_silence();
      queue_poll(REG_WIND_SPEED, 16'd2000);
      queue_poll(REG_WIND_DIR, 16'h7FFF);
      queue_poll(REG_AIR_TEMP, 16'(-400));
      queue_poll(REG_AIR_TEMP, 16'd399);
      queue_poll(REG_HUMIDITY, 16'hFFFF);
      queue_poll(REG_HUMIDITY, 16'd1000);
      queue_poll(REG_DEWPOINT, 16'(-5));
      queue_poll(REG_PRESSURE, 16'd6665);
      queue_poll(REG_PRESSURE, 16'd9331);
      queue_poll(REG_PRESSURE, 16'h8000);
      queue_poll(16'hFFFF, 16'h8000);
      // answer with nothing latched
      queue_answer(16'd123, 1'b0);
      queue_silence();
      // broken checksums: request, answer, second half of a poll
      queue_request(REG_HUMIDITY, 1'b1);
      queue_silence();
      queue_answer(16'd10, 1'b1);
      queue_silence();
      queue_request(REG_AIR_TEMP, 1'b0);
      queue_answer(16'd10, 1'b1);
      queue_silence();
      // a bad length in between keeps the latch
      queue_request(REG_HUMIDITY, 1'b0);
      queue_silence();
      queue_noise(1);
      queue_answer(16'd500, 1'b0);
      queue_silence();
      queue_noise(16);
      queue_noise(20);
   endtask

   task automatic random_traffic(input int budget);
      int          first;
      int          pick;
      logic        bad;
      logic [15:0] addr;
      first = queued_count;
      while (queued_count - first < budget) begin
         pick = $urandom_range(0, 99);
         addr = pick_register();
         if (pick < 30) begin
            queue_request(addr, 1'b0);
            queue_silence();
            queue_answer(pick_value(addr), 1'b0);
            queue_silence();
         end else if (pick < 60) begin
            queue_poll(addr, pick_value(addr));
         end else if (pick < 67) begin
            queue_answer(pick_value(addr), 1'b0);
            queue_silence();
         end else if (pick < 76) begin
            case ($urandom_range(0, 2))
               0: queue_request(addr, 1'b1);
               1: queue_answer(pick_value(addr), 1'b1);
               default: begin
                  bad = 1'($urandom_range(0, 1));
                  queue_request(addr, bad);
                  queue_answer(pick_value(addr), !bad || 1'($urandom_range(0, 1)));
               end
            endcase
            queue_silence();
         end else if (pick < 84) begin
            queue_request(addr, 1'b0);
            queue_silence();
            queue_noise($urandom_range(1, 6));
            queue_answer(pick_value(addr), 1'b0);
            queue_silence();
         end else if (pick < 92) begin
            queue_noise($urandom_range(1, 20));
         end else if (pick < 96) begin
            queue_silence();
         end else begin
            queue_request(addr, 1'b0);
            queue_silence();
         end
      end
   endtask

   task automatic write_csr(input logic index, input logic [3:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // hold until every item is sent and every report is back, then settle
   task automatic drain();
      do @(posedge clock);
      while (line_queue.size() != 0 || req_ch.valid || expected_reports.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin
      line_item_type item;
      logic          pause;
      logic          stall;
      pause = (idle_plan == IDLE_SENDER && $urandom_range(0, 99) < 72) ||
              (idle_plan == IDLE_BOTH   && $urandom_range(0, 99) < 20);
      stall = (idle_plan == IDLE_RECEIVER && $urandom_range(0, 99) < 72) ||
              (idle_plan == IDLE_BOTH     && $urandom_range(0, 99) < 20);
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (line_queue.size() != 0 && !pause) begin
            item = line_queue.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.kind      <= item.kind;
            req_ch.data_byte <= item.data;
         end else begin
            req_ch.valid     <= 1'b0;
            req_ch.data_byte <= 8'($urandom);
         end
      end
      rsp_ch.ready <= !stall;
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      result_type want;
      logic       req_fire;
      logic       rsp_fire;
      if (reset) begin
         clear_frame();
         latched_reg  = '0;
         cfg_link     = 1'b0;
         cfg_manual   = '0;
         req_taken    = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_fire  = req_ch.valid && req_ch.ready;
         rsp_fire  = rsp_ch.valid && rsp_ch.ready;
         req_taken = req_fire;
         if (rsp_fire) begin
            if (expected_reports.size() == 0) begin
               report_mismatch($sformatf("report with none pending: status %0d",
                                         rsp_ch.status));
            end else begin
               want = expected_reports.pop_front();
               if (rsp_ch.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d", rsp_ch.status,
                                            want.status));
               if (rsp_ch.param !== want.param)
                  report_mismatch($sformatf("param %0d, want %0d", rsp_ch.param,
                                            want.param));
               if (rsp_ch.raw_value !== want.raw_value)
                  report_mismatch($sformatf("raw_value %0d, want %0d", rsp_ch.raw_value,
                                            want.raw_value));
               if (rsp_ch.scaled_value !== want.scaled_value)
                  report_mismatch($sformatf("scaled_value %0d, want %0d",
                                            rsp_ch.scaled_value, want.scaled_value));
               if (rsp_ch.accepted !== want.accepted)
                  report_mismatch($sformatf("accepted %0b, want %0b", rsp_ch.accepted,
                                            want.accepted));
            end
         end
         if (req_fire) begin
            if (req_ch.kind == KIND_SILENCE) take_silence();
            else take_byte(req_ch.data_byte);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_LINK_ENABLED: cfg_link   = csr_wdata[0];
               CSR_MANUAL_MASK:  cfg_manual = csr_wdata;
               default:          ;
            endcase
         end
         if (req_fire || rsp_fire) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      logic       link;
      logic [3:0] mask;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.kind      = KIND_BYTE;
      req_ch.data_byte = 8'h00;
      rsp_ch.ready     = 1'b0;
      csr_we           = 1'b0;
      csr_index        = CSR_LINK_ENABLED;
      csr_wdata        = 4'h0;
      queued_count     = 0;
      mismatch_count   = 0;
      wire_crc         = CRC_INIT;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       begin link = 1'b1; mask = 4'h0; idle_plan = IDLE_NONE;     end
            1:       begin link = 1'b0; mask = 4'h0; idle_plan = IDLE_SENDER;   end
            2:       begin link = 1'b1; mask = 4'hF; idle_plan = IDLE_RECEIVER; end
            3:       begin link = 1'b1; mask = 4'h5; idle_plan = IDLE_BOTH;     end
            4:       begin link = 1'b1; mask = 4'hA; idle_plan = IDLE_NONE;     end
            default: begin
               link      = 1'b1;
               mask      = 4'($urandom_range(0, 15));
               idle_plan = IDLE_RECEIVER;
            end
         endcase
         write_csr(CSR_LINK_ENABLED, {3'b000, link});
         write_csr(CSR_MANUAL_MASK, mask);
         if (ph == 0) directed_frames();
         random_traffic(RANDOM_ITEMS);
         drain();
      end

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: files.f
src/mbs_pkg.sv
src/mbs_req_if.sv
src/mbs_rsp_if.sv
src/mbs_frame.sv
src/mbs_decode.sv
src/modbus_meteo_frame_sniffer.sv
tb/testbench.sv
